### src/tpmp_pkg.sv
// Shared constants and types for the tile point Mercator projector.
`default_nettype none

package tpmp_pkg;

  // Screen geometry and output limit
  parameter int SCREEN_SIZE = 240;
  parameter int CLAMP_LIMIT = 20000;

  // Field widths
  parameter int TILE_LAT_W = 31;
  parameter int TILE_LON_W = 32;
  parameter int OFFSET_W   = 16;
  parameter int UNIT_W     = 24;
  parameter int SCREEN_W   = 16;
  parameter int IN_DATA_W  = 96;
  parameter int OUT_DATA_W = 32;

  // Configuration port
  parameter int CFG_IDX_W  = 3;
  parameter int CFG_DATA_W = 64;

  // Degree conversion: round(delta * 2^24 / 10^7) = floor((mag * 2^17 + 39062) / 78125)
  parameter int DELTA_W     = 42;
  parameter int DEG_W       = 32;
  parameter int MAG_W       = 31;
  parameter int NUM_W       = 48;
  parameter int DEG_SHIFT   = 17;
  parameter int DELTA_LIMIT = 1280000000;
  parameter logic [31:0] DEG_RECIP = 32'd3602879701;  // floor(2^48 / 78125)
  parameter logic [16:0] DEG_DIV   = 17'd78125;
  parameter logic [15:0] DEG_RND   = 16'd39062;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_LAT = 3'd0,
    REG_CENTER_LON = 3'd1,
    REG_COORD_UNIT = 3'd2,
    REG_LON_GAIN   = 3'd3,
    REG_LAT_GAIN   = 3'd4,
    REG_CURVE      = 3'd5,
    REG_ROTATION   = 3'd6,
    REG_TRACK_UP   = 3'd7
  } cfg_reg_t;

endpackage

`default_nettype wire

### src/tile_point_mercator_projector.sv
// Top level: pipelined tile point decode, Mercator projection, rotation and clamp.
`default_nettype none

// Projects one quantized map point per clock to a clamped screen position. Each
// request (tile origin plus two offsets) runs through a 17-stage pipeline: offset
// scaling, centre subtraction, a five-stage degree conversion, the Mercator cubic
// (three chained 32x32 multiplies, each with its own register), rotation and the
// final clamp, followed by a two-entry output buffer. Sustained rate is one request
// per cycle while no result is parked there. The buffer lets the pipeline keep taking
// requests while one result waits; in_tready drops only when a second result is
// parked behind a stalled output. Configuration must be written while idle.
module tile_point_mercator_projector (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // tile_lat_e7[30:0], tile_lon_e7[62:31], lat_offset[78:63], lon_offset[94:79], pad
  input  logic [tpmp_pkg::IN_DATA_W-1:0]         in_tdata,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // screen_x[15:0], screen_y[31:16]
  output logic [tpmp_pkg::OUT_DATA_W-1:0]        out_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  input  logic                                   cfg_we,
  input  logic [tpmp_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [tpmp_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import tpmp_pkg::*;

  localparam int NSTAGE = 17;
  localparam int PROD_W = OFFSET_W + UNIT_W + 1;
  localparam int SAT_W  = 41;
  localparam int PIX_W  = 20;
  localparam logic signed [SAT_W-1:0] SAT_HI = 41'sd2147483647;
  localparam logic signed [SAT_W-1:0] SAT_LO = -41'sd2147483648;
  localparam logic signed [SAT_W-1:0] F_ONE  = 41'sd1073741824;
  localparam logic signed [PIX_W-1:0] CX     = PIX_W'(SCREEN_SIZE / 2);
  localparam logic signed [PIX_W-1:0] CY_UP  = PIX_W'(SCREEN_SIZE * 3 / 4);
  localparam logic signed [PIX_W-1:0] LIM_P  = PIX_W'(CLAMP_LIMIT);
  localparam logic signed [PIX_W-1:0] LIM_N  = -LIM_P;

  function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) begin
      r = 32'sh7FFFFFFF;
    end else if (v < SAT_LO) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [SCREEN_W-1:0] clamp_pix(input logic signed [PIX_W-1:0] v);
    logic signed [PIX_W-1:0] r;
    if (v > LIM_P) begin
      r = LIM_P;
    end else if (v < LIM_N) begin
      r = LIM_N;
    end else begin
      r = v;
    end
    return r[SCREEN_W-1:0];
  endfunction

  // configuration registers
  logic signed [TILE_LAT_W-1:0] center_lat_r;
  logic signed [TILE_LON_W-1:0] center_lon_r;
  logic [UNIT_W-1:0]            coord_unit_r;
  logic [31:0]                  lon_gain_r, lat_gain_r;
  logic [63:0]                  curve_coeffs_r;
  logic [31:0]                  rotation_r;
  logic                         track_up_r;

  logic signed [31:0] c2, c3;
  logic signed [15:0] ca, sa;

  // flow control
  logic              en;
  logic [NSTAGE-1:0] v_r;

  // stage 1
  logic signed [PROD_W-1:0]     lat_prod_nxt, lon_prod_nxt, lat_prod_r, lon_prod_r;
  logic signed [TILE_LAT_W-1:0] tile_lat_r;
  logic signed [TILE_LON_W-1:0] tile_lon_r;
  // stage 2
  logic signed [DELTA_W-1:0]    dlat_nxt, dlon_nxt, dlat_r, dlon_r;
  // stages 3..7
  logic signed [DEG_W-1:0]      deg_lat, deg_lon;
  // stage 8
  logic signed [64:0]           mul_x_r, mul_y0_r;
  logic signed [63:0]           mul_c3_r;
  logic signed [31:0]           d8_r;
  // stage 9
  logic signed [31:0]           x9_r, y09_r, s9_r, d9_r;
  // stage 10
  logic signed [63:0]           mul_ds_r;
  logic signed [31:0]           x10_r, y010_r;
  // stage 11
  logic signed [31:0]           f11_r, x11_r, y011_r;
  // stage 12
  logic signed [63:0]           mul_yf_r;
  logic signed [31:0]           x12_r;
  // stage 13
  logic signed [31:0]           x13_r, y13_r;
  // stage 14
  logic signed [47:0]           xc_r, ys_r, xs_r, yc_r;
  // stage 15
  logic signed [48:0]           rx_sum, ry_sum;
  logic signed [34:0]           rx_r, ry_r;
  // stage 16
  logic signed [18:0]           tx_nxt, ty_nxt, tx_r, ty_r;
  // stage 17
  logic signed [PIX_W-1:0]      cy, sx_full, sy_full;
  logic signed [SCREEN_W-1:0]   sx_r, sy_r;

  // output buffer
  logic                  last_fire;
  logic [OUT_DATA_W-1:0] last_data;
  logic                  out_valid_nxt, out_valid_r, skid_valid_nxt, skid_valid_r;
  logic [OUT_DATA_W-1:0] out_data_nxt, out_data_r, skid_data_nxt, skid_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_lat_r   <= '0;
      center_lon_r   <= '0;
      coord_unit_r   <= UNIT_W'(1);
      lon_gain_r     <= 32'd65536;
      lat_gain_r     <= 32'd65536;
      curve_coeffs_r <= '0;
      rotation_r     <= 32'h4000_0000;
      track_up_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_CENTER_LAT: center_lat_r   <= cfg_data[TILE_LAT_W-1:0];
        REG_CENTER_LON: center_lon_r   <= cfg_data[TILE_LON_W-1:0];
        REG_COORD_UNIT: coord_unit_r   <= cfg_data[UNIT_W-1:0];
        REG_LON_GAIN:   lon_gain_r     <= cfg_data[31:0];
        REG_LAT_GAIN:   lat_gain_r     <= cfg_data[31:0];
        REG_CURVE:      curve_coeffs_r <= cfg_data;
        REG_ROTATION:   rotation_r     <= cfg_data[31:0];
        REG_TRACK_UP:   track_up_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign c2 = $signed(curve_coeffs_r[63:32]);
  assign c3 = $signed(curve_coeffs_r[31:0]);
  assign ca = $signed(rotation_r[31:16]);
  assign sa = $signed(rotation_r[15:0]);

  // hold the whole pipeline only while a second result is parked
  assign en        = !skid_valid_r;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NSTAGE-2:0], in_tvalid};
    end
  end

  // stage 1: scale offsets
  assign lat_prod_nxt = $signed(in_tdata[78:63]) * $signed({1'b0, coord_unit_r});
  assign lon_prod_nxt = $signed(in_tdata[94:79]) * $signed({1'b0, coord_unit_r});

  // stage 2: absolute position minus map centre
  assign dlat_nxt = DELTA_W'(tile_lat_r) + DELTA_W'(lat_prod_r) - DELTA_W'(center_lat_r);
  assign dlon_nxt = DELTA_W'(tile_lon_r) + DELTA_W'(lon_prod_r) - DELTA_W'(center_lon_r);

  tpmp_deg_conv u_deg_lat (
    .clk     (clk),
    .en      (en),
    .delta_i (dlat_r),
    .deg_o   (deg_lat)
  );

  tpmp_deg_conv u_deg_lon (
    .clk     (clk),
    .en      (en),
    .delta_i (dlon_r),
    .deg_o   (deg_lon)
  );

  // stage 15: rotate
  assign rx_sum = 49'(xc_r) - 49'(ys_r);
  assign ry_sum = 49'(xs_r) + 49'(yc_r);

  // stage 16: integer pixel part toward zero
  assign tx_nxt = rx_r[34:16] + {18'd0, rx_r[34] && (rx_r[15:0] != 16'd0)};
  assign ty_nxt = ry_r[34:16] + {18'd0, ry_r[34] && (ry_r[15:0] != 16'd0)};

  // stage 17: screen offset
  assign cy      = track_up_r ? CY_UP : CX;
  assign sx_full = CX + PIX_W'(tx_r);
  assign sy_full = cy - PIX_W'(ty_r);

  always_ff @(posedge clk) begin
    if (en) begin
      lat_prod_r <= lat_prod_nxt;
      lon_prod_r <= lon_prod_nxt;
      tile_lat_r <= $signed(in_tdata[30:0]);
      tile_lon_r <= $signed(in_tdata[62:31]);

      dlat_r <= dlat_nxt;
      dlon_r <= dlon_nxt;

      mul_x_r  <= deg_lon * $signed({1'b0, lon_gain_r});
      mul_y0_r <= deg_lat * $signed({1'b0, lat_gain_r});
      mul_c3_r <= deg_lat * c3;
      d8_r     <= deg_lat;

      x9_r  <= sat32(SAT_W'($signed(mul_x_r[64:24])));
      y09_r <= sat32(SAT_W'($signed(mul_y0_r[64:24])));
      s9_r  <= sat32(SAT_W'($signed(mul_c3_r[63:24])) + SAT_W'(c2));
      d9_r  <= d8_r;

      mul_ds_r <= d9_r * s9_r;
      x10_r    <= x9_r;
      y010_r   <= y09_r;

      f11_r  <= sat32(SAT_W'($signed(mul_ds_r[63:24])) + F_ONE);
      x11_r  <= x10_r;
      y011_r <= y010_r;

      mul_yf_r <= y011_r * f11_r;
      x12_r    <= x11_r;

      y13_r <= sat32(SAT_W'($signed(mul_yf_r[63:30])));
      x13_r <= x12_r;

      xc_r <= x13_r * ca;
      ys_r <= y13_r * sa;
      xs_r <= x13_r * sa;
      yc_r <= y13_r * ca;

      rx_r <= rx_sum[48:14];
      ry_r <= ry_sum[48:14];

      tx_r <= tx_nxt;
      ty_r <= ty_nxt;

      sx_r <= clamp_pix(sx_full);
      sy_r <= clamp_pix(sy_full);
    end
  end

  assign last_fire = en && v_r[NSTAGE-1];
  assign last_data = {sy_r, sx_r};

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = last_fire;
        out_data_nxt  = last_data;
      end
    end else if (last_fire) begin
      // park the result behind the stalled output
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = last_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

### src/tpmp_deg_conv.sv
// Five-stage conversion of a 1e-7 degree delta into Q8.24 degrees.
`default_nettype none

module tpmp_deg_conv (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [tpmp_pkg::DELTA_W-1:0] delta_i,
  output logic signed [tpmp_pkg::DEG_W-1:0]   deg_o
);
  import tpmp_pkg::*;

  localparam logic signed [DELTA_W-1:0] LIM_POS = DELTA_W'(DELTA_LIMIT);
  localparam logic signed [DELTA_W-1:0] LIM_NEG = -LIM_POS;
  localparam logic [NUM_W-1:0] DIV_1 = NUM_W'(DEG_DIV);
  localparam logic [NUM_W-1:0] DIV_2 = NUM_W'({DEG_DIV, 1'b0});

  // stage A: clamp and magnitude
  logic signed [DELTA_W-1:0] delta_neg;
  logic [MAG_W-1:0]          mag_a_nxt, mag_a_r;
  logic                      neg_a_nxt, neg_a_r;
  // stage B: quotient estimate
  logic [2*DEG_W-1:0]        est;
  logic [DEG_W-1:0]          qe_b_r;
  logic [MAG_W-1:0]          mag_b_r;
  logic                      neg_b_r;
  // stage C: back-multiply
  logic [NUM_W:0]            prod_full;
  logic [NUM_W-1:0]          prod_c_r;
  logic [DEG_W-1:0]          qe_c_r;
  logic [MAG_W-1:0]          mag_c_r;
  logic                      neg_c_r;
  // stage D: remainder correction
  logic [NUM_W-1:0]          num, rem;
  logic [DEG_W-1:0]          q_d_nxt, q_d_r;
  logic                      neg_d_r;
  // stage E: sign and saturation
  logic signed [DEG_W-1:0]   deg_e_nxt, deg_e_r;

  always_comb begin
    delta_neg = -delta_i;
    neg_a_nxt = delta_i[DELTA_W-1];
    if (delta_i > LIM_POS || delta_i < LIM_NEG) begin
      mag_a_nxt = LIM_POS[MAG_W-1:0];
    end else if (neg_a_nxt) begin
      mag_a_nxt = delta_neg[MAG_W-1:0];
    end else begin
      mag_a_nxt = delta_i[MAG_W-1:0];
    end
  end

  // estimate sits at most two below the true quotient
  assign est = {mag_a_r, 1'b0} * DEG_RECIP;

  assign prod_full = qe_b_r * DEG_DIV;

  always_comb begin
    num = {mag_c_r, {DEG_SHIFT{1'b0}}} + NUM_W'(DEG_RND);
    rem = num - prod_c_r;
    if (rem >= DIV_2) begin
      q_d_nxt = qe_c_r + DEG_W'(2);
    end else if (rem >= DIV_1) begin
      q_d_nxt = qe_c_r + DEG_W'(1);
    end else begin
      q_d_nxt = qe_c_r;
    end
  end

  always_comb begin
    if (neg_d_r) begin
      deg_e_nxt = ~q_d_r + DEG_W'(1);
    end else if (q_d_r[DEG_W-1]) begin
      deg_e_nxt = {1'b0, {(DEG_W-1){1'b1}}};
    end else begin
      deg_e_nxt = q_d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_a_r  <= mag_a_nxt;
      neg_a_r  <= neg_a_nxt;
      qe_b_r   <= est[2*DEG_W-1:DEG_W];
      mag_b_r  <= mag_a_r;
      neg_b_r  <= neg_a_r;
      prod_c_r <= prod_full[NUM_W-1:0];
      qe_c_r   <= qe_b_r;
      mag_c_r  <= mag_b_r;
      neg_c_r  <= neg_b_r;
      q_d_r    <= q_d_nxt;
      neg_d_r  <= neg_c_r;
      deg_e_r  <= deg_e_nxt;
    end
  end

  assign deg_o = deg_e_r;

endmodule

`default_nettype wire

### src/tpmp_checker.sv
// Port-level checks for the projector, bound to the top level.
`default_nettype none

module tpmp_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tready,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [tpmp_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import tpmp_pkg::*;

  localparam logic signed [SCREEN_W-1:0] LIM_P = SCREEN_W'(CLAMP_LIMIT);
  localparam logic signed [SCREEN_W-1:0] LIM_N = -LIM_P;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> $past(out_tvalid) && !$past(out_tready))
    else $error("request held off without an output stall");

  a_ready_stays: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready && !out_tready |=> !in_tready)
    else $error("request taken while both result slots are full");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[15:0]) <= LIM_P) && ($signed(out_tdata[15:0]) >= LIM_N)
                && ($signed(out_tdata[31:16]) <= LIM_P) && ($signed(out_tdata[31:16]) >= LIM_N))
    else $error("screen position outside the clamp range");

endmodule

bind tile_point_mercator_projector tpmp_checker u_tpmp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

### sim/testbench.sv
// Self-checking testbench for the tile point Mercator projector.
`timescale 1ns / 1ps

module testbench;
  import tpmp_pkg::*;

  typedef struct packed {
    logic signed [15:0] lon_off;
    logic signed [15:0] lat_off;
    logic signed [31:0] lon;
    logic signed [30:0] lat;
  } map_point_t;

  typedef struct packed {
    logic signed [15:0] sy;
    logic signed [15:0] sx;
  } screen_xy_t;

  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_POINTS  = 115;
  localparam int HOLD_CYCLES   = 300;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_we = 1'b0;
  cfg_reg_t              cfg_index = REG_CENTER_LAT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Register shadow, reset values
  logic signed [30:0] ctr_lat = '0;
  logic signed [31:0] ctr_lon = '0;
  logic [23:0]        unit_step = 24'd1;
  logic [31:0]        lon_gain = 32'd65536;
  logic [31:0]        lat_gain = 32'd65536;
  logic [63:0]        curve = '0;
  logic [31:0]        rot = 32'h4000_0000;
  logic               track = 1'b0;

  map_point_t pending_points[$];
  screen_xy_t expected_xy[$];
  int         mismatch_cnt = 0;

  // Idling knobs set per phase
  bit send_idle = 1'b0;
  bit recv_idle = 1'b0;
  bit hold_req = 1'b0;

  tile_point_mercator_projector DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clamp_abs(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // e7 degrees to Q8.24 degrees, rounded half away from zero
  function automatic longint e7_to_q24(longint delta);
    longint dc, mag, q;
    dc = clamp_abs(delta, longint'(DELTA_LIMIT));
    mag = (dc < 0) ? -dc : dc;
    q = (mag * 64'sd16777216 + 64'sd5000000) / 64'sd10000000;
    return sat32((dc < 0) ? -q : q);
  endfunction

  // whole pixels of a Q.16 value, toward zero
  function automatic longint pixel_part(longint v);
    if (v >= 0) return v >>> 16;
    return -((-v) >>> 16);
  endfunction

  function automatic screen_xy_t project_point(map_point_t pt);
    longint abs_lat, abs_lon, dlat, dlon, c2, c3, ca, sa;
    longint x, y0, s, f, y, rx, ry, cy;
    screen_xy_t res;
    abs_lat = longint'(pt.lat) + longint'(pt.lat_off) * longint'(unit_step);
    abs_lon = longint'(pt.lon) + longint'(pt.lon_off) * longint'(unit_step);
    dlat = e7_to_q24(abs_lat - longint'(ctr_lat));
    dlon = e7_to_q24(abs_lon - longint'(ctr_lon));
    c2 = longint'($signed(curve[63:32]));
    c3 = longint'($signed(curve[31:0]));
    ca = longint'($signed(rot[31:16]));
    sa = longint'($signed(rot[15:0]));
    x  = sat32((dlon * longint'(lon_gain)) >>> 24);
    y0 = sat32((dlat * longint'(lat_gain)) >>> 24);
    s  = sat32(c2 + ((dlat * c3) >>> 24));
    f  = sat32(64'sd1073741824 + ((dlat * s) >>> 24));
    y  = sat32((y0 * f) >>> 30);
    rx = (x * ca - y * sa) >>> 14;
    ry = (x * sa + y * ca) >>> 14;
    cy = track ? longint'(SCREEN_SIZE * 3 / 4) : longint'(SCREEN_SIZE / 2);
    res.sx = 16'(clamp_abs(longint'(SCREEN_SIZE / 2) + pixel_part(rx), CLAMP_LIMIT));
    res.sy = 16'(clamp_abs(cy - pixel_part(ry), CLAMP_LIMIT));
    return res;
  endfunction

  // Driver: present requests from the pending queue with random gaps
  map_point_t cur_point;
  int         send_gap = 0;
  bit         valid_next;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      valid_next = in_tvalid;
      if (in_tvalid && in_tready) begin
        expected_xy.push_back(project_point(cur_point));
        valid_next = 1'b0;
        send_gap = send_idle ? $urandom_range(0, 15) : 0;
      end
      if (!valid_next) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_points.size() > 0) begin
          cur_point = pending_points.pop_front();
          in_tdata <= {1'b0, cur_point};
          valid_next = 1'b1;
        end
      end
      in_tvalid <= valid_next;
    end
  end

  // Monitor: accept results with random stalls, check against the oldest prediction
  int         recv_gap = 0;
  int         hold_left = 0;
  bit         hold_taken = 1'b0;
  screen_xy_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_xy.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected result: screen_x %0d screen_y %0d",
                     $signed(out_tdata[15:0]), $signed(out_tdata[31:16]));
        end else begin
          want = expected_xy.pop_front();
          if (out_tdata[15:0] !== want.sx) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("screen_x mismatch: expected %0d, got %0d",
                       want.sx, $signed(out_tdata[15:0]));
          end
          if (out_tdata[31:16] !== want.sy) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("screen_y mismatch: expected %0d, got %0d",
                       want.sy, $signed(out_tdata[31:16]));
          end
        end
        recv_gap = recv_idle ? $urandom_range(0, 15) : 0;
      end
      if (hold_req && !hold_taken) begin
        hold_left = HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_CENTER_LAT: ctr_lat = val[30:0];
      REG_CENTER_LON: ctr_lon = val[31:0];
      REG_COORD_UNIT: unit_step = val[23:0];
      REG_LON_GAIN:   lon_gain = val[31:0];
      REG_LAT_GAIN:   lat_gain = val[31:0];
      REG_CURVE:      curve = val;
      REG_ROTATION:   rot = val[31:0];
      REG_TRACK_UP:   track = val[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_all_regs(longint clat, longint clon, logic [23:0] su,
                              logic [31:0] gx, logic [31:0] gy, logic [63:0] cc,
                              logic [31:0] rr, bit tu);
    write_reg(REG_CENTER_LAT, clat);
    write_reg(REG_CENTER_LON, clon);
    write_reg(REG_COORD_UNIT, su);
    write_reg(REG_LON_GAIN, gx);
    write_reg(REG_LAT_GAIN, gy);
    write_reg(REG_CURVE, cc);
    write_reg(REG_ROTATION, rr);
    write_reg(REG_TRACK_UP, tu);
  endtask

  task automatic add_point(longint lat, longint lon, int lat_off, int lon_off);
    map_point_t pt;
    pt.lat = 31'(lat);
    pt.lon = 32'(lon);
    pt.lat_off = 16'(lat_off);
    pt.lon_off = 16'(lon_off);
    pending_points.push_back(pt);
  endtask

  // Block until every request is sent and every result is back
  task automatic wait_idle();
    while (pending_points.size() != 0 || in_tvalid || expected_xy.size() != 0)
      @(posedge clk);
  endtask

  function automatic longint rand_signed(int unsigned bits);
    longint m;
    m = longint'({$urandom, $urandom}) & ((64'sd1 << bits) - 1);
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  function automatic logic [31:0] rand_gain();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(32'h0001_0000, 32'h0400_0000);
    endcase
  endfunction

  task automatic randomize_regs();
    longint      clat, clon;
    logic [23:0] su;
    logic [63:0] cc;
    logic [31:0] rr;
    real         ang;
    int          cs, sn;
    case ($urandom_range(0, 3))
      0: clat = -64'sd900000000;
      1: clat = 64'sd900000000;
      default: clat = longint'($urandom_range(0, 32'd1800000000)) - 64'sd900000000;
    endcase
    case ($urandom_range(0, 3))
      0: clon = -64'sd1800000000;
      1: clon = 64'sd1800000000;
      default: clon = longint'($urandom_range(0, 32'd3600000000)) - 64'sd1800000000;
    endcase
    case ($urandom_range(0, 5))
      0: su = 24'd0;
      1: su = 24'd1;
      2: su = 24'hFF_FFFF;
      3: su = $urandom;
      default: su = $urandom_range(1, 1000);
    endcase
    case ($urandom_range(0, 5))
      0: cc = '0;
      1: cc = 64'h7FFF_FFFF_7FFF_FFFF;
      2: cc = 64'h8000_0000_8000_0000;
      3: cc = {$urandom, $urandom};
      default: cc = {32'(rand_signed($urandom_range(0, 29))),
                     32'(rand_signed($urandom_range(0, 29)))};
    endcase
    if ($urandom_range(0, 3) == 0) begin
      rr = $urandom;
    end else begin
      ang = $urandom_range(0, 359) * 3.14159265358979 / 180.0;
      cs = $rtoi($cos(ang) * 16384.0);
      sn = $rtoi($sin(ang) * 16384.0);
      rr = {16'(cs), 16'(sn)};
    end
    set_all_regs(clat, clon, su, rand_gain(), rand_gain(), cc, rr, $urandom_range(0, 1));
  endtask

  function automatic map_point_t random_point();
    map_point_t pt;
    logic [95:0] rbits;
    if ($urandom_range(0, 9) < 3) begin
      rbits = {$urandom, $urandom, $urandom};
      pt = rbits[94:0];
    end else begin
      // land near the centre so the projection stays on screen more often
      pt.lat = 31'(longint'(ctr_lat) + rand_signed($urandom_range(0, 28)));
      pt.lon = 32'(longint'(ctr_lon) + rand_signed($urandom_range(0, 28)));
      pt.lat_off = 16'(rand_signed($urandom_range(0, 15)));
      pt.lon_off = 16'(rand_signed($urandom_range(0, 15)));
    end
    return pt;
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: zero, field extremes, range limits
    send_idle = 1'b1;
    recv_idle = 1'b1;
    add_point(0, 0, 0, 0);
    add_point(64'sd1073741823, 64'sd2147483647, 32767, 32767);
    add_point(-64'sd1073741824, -64'sd2147483648, -32768, -32768);
    add_point(900000000, 1800000000, 0, 0);
    add_point(-900000000, -1800000000, 0, 0);
    add_point(12345, -67890, 5, -7);
    wait_idle();

    // Largest step and gains, curvature at the positive limit, track-up
    set_all_regs(900000000, -1800000000, 24'hFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 64'h7FFF_FFFF_7FFF_FFFF, 32'h7FFF_8000, 1'b1);
    add_point(0, 0, 0, 0);
    add_point(64'sd1073741823, 64'sd2147483647, 32767, 32767);
    add_point(-64'sd1073741824, -64'sd2147483648, -32768, -32768);
    add_point(900000000, -1800000000, 1, -1);
    add_point(899000000, -1799000000, 0, 0);
    wait_idle();

    // Zero step, curvature at the negative limit, quarter turn
    set_all_regs(-900000000, 1800000000, 24'd0, 32'd6553600, 32'd6553600,
                 64'h8000_0000_8000_0000, 32'h0000_4000, 1'b0);
    add_point(-900000000, 1800000000, 0, 0);
    add_point(-890000000, 1790000000, 32767, -32768);
    add_point(-899900000, 1795000000, -100, 100);
    add_point(64'sd1073741823, -64'sd2147483648, 0, 0);
    wait_idle();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      randomize_regs();
      send_idle = (ph % 3 != 1) && (ph != 2);
      recv_idle = (ph % 3 == 0);
      // back up the output while requests keep coming
      if (ph == 2) hold_req = 1'b1;
      for (int i = 0; i < PHASE_POINTS; i++)
        pending_points.push_back(random_point());
      wait_idle();
    end

    repeat (40) @(posedge clk);
    if (mismatch_cnt == 0 && expected_xy.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("Verification failed");
    $finish;
  end

endmodule

### filelist.f
src/tpmp_pkg.sv
src/tpmp_deg_conv.sv
src/tile_point_mercator_projector.sv
src/tpmp_checker.sv
sim/testbench.sv
